// ===== hdl/tbff_pkg.sv =====
// Package with the shared types and constants of the touch boost frequency floor block.
`timescale 1ns / 1ps
`default_nettype none
package tbff_pkg;

    localparam int unsigned KHZ_W     = 24;
    localparam int unsigned PCT_W     = 7;
    localparam int unsigned MS_W      = 16;
    localparam int unsigned CFG_IDX_W = 4;
    localparam int unsigned CFG_DAT_W = 16;

    // Item kinds carried in the action field.
    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_TOUCH = 2'd1,
        ACT_QUERY = 2'd2
    } t_action;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERCENT  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DURATION = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THROTTLE = 4'd3;

    localparam logic             RST_ENABLE   = 1'b1;
    localparam logic [PCT_W-1:0] RST_PERCENT  = 7'd65;
    localparam logic [MS_W-1:0]  RST_DURATION = 16'd200;
    localparam logic [MS_W-1:0]  RST_THROTTLE = 16'd50;

    // Division by 100 of a 24-bit value: multiply by ceil(2^37 / 100) and keep
    // the bits from 37 up. The constant is exact for every 32-bit dividend.
    localparam int unsigned              DIV100_MUL_W = 31;
    localparam logic [DIV100_MUL_W-1:0]  DIV100_MUL   = 31'd1374389535;
    localparam int unsigned              DIV100_SHIFT = 37;
    localparam int unsigned              PROD_W       = KHZ_W + DIV100_MUL_W;
    localparam int unsigned              QUOT_W       = 18;
    localparam int unsigned              TARGET_W     = QUOT_W + PCT_W;

endpackage
`default_nettype wire

// ===== hdl/tbff_if.sv =====
// Handshake channel interfaces for the input items, the result items and the register writes.
`timescale 1ns / 1ps
`default_nettype none
interface tbff_in_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   action;
    logic [tbff_pkg::KHZ_W-1:0]   policy_max_khz;
    logic [tbff_pkg::KHZ_W-1:0]   hw_min_khz;
    logic [tbff_pkg::KHZ_W-1:0]   policy_min_khz;

    modport source (
        output valid, action, policy_max_khz, hw_min_khz, policy_min_khz,
        input  ready
    );
    modport sink (
        input  valid, action, policy_max_khz, hw_min_khz, policy_min_khz,
        output ready
    );
endinterface

interface tbff_out_if;
    logic                         valid;
    logic                         ready;
    logic [tbff_pkg::KHZ_W-1:0]   new_min_khz;
    logic                         boosting;
    logic                         update_request;
    logic                         touch_taken;

    modport source (
        output valid, new_min_khz, boosting, update_request, touch_taken,
        input  ready
    );
    modport sink (
        input  valid, new_min_khz, boosting, update_request, touch_taken,
        output ready
    );
endinterface

interface tbff_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [tbff_pkg::CFG_IDX_W-1:0]   index;
    logic [tbff_pkg::CFG_DAT_W-1:0]   data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface
`default_nettype wire

// ===== hdl/touch_boost_frequency_floor_core.sv =====
// Top level of the touch boost frequency floor block: timers, boost state and floor pipeline.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
// Items arrive on i_in (tick, touch or policy query) with a valid/ready handshake,
// and each accepted item yields exactly one result item on o_out. Registers are
// written through i_cfg, which is always ready; write them only while no item
// is in flight.
// Timers and boost state update at the edge where an item is accepted. The
// floor for a query goes through two register stages: the first holds the
// policy maximum divided by 100 (a reciprocal multiply), the second scales it
// by the percent and clamps it. A result item becomes valid once its item has moved
// from the first stage into the output stage, and one item per cycle is sustained
// while the receiver keeps o_out.ready high.
// When the receiver holds o_out.ready low the two stages fill and then i_in.ready
// drops; nothing is lost or repeated. An empty output stage always accepts.
// Synchronous reset (i_rst_n low) loads the register defaults (enabled, 65
// percent, 200 ms boost, 50 ms throttle), ends any boost, clears both timers
// and empties the pipeline.
module touch_boost_frequency_floor_core (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    tbff_in_if.sink     i_in,
    tbff_cfg_if.sink    i_cfg,
    tbff_out_if.source  o_out
);
    import tbff_pkg::*;

    // Configuration registers.
    logic             r_enable;
    logic [PCT_W-1:0] r_percent;
    logic [MS_W-1:0]  r_duration;
    logic [MS_W-1:0]  r_throttle;

    // Block state.
    logic             r_boost_active, n_boost_active;
    logic [MS_W-1:0]  r_boost_left,   n_boost_left;
    logic [MS_W-1:0]  r_throttle_left, n_throttle_left;

    // First stage.
    logic              r1_valid;
    logic              r1_boost_query;
    logic              r1_boosting;
    logic              r1_update;
    logic              r1_taken;
    logic [KHZ_W-1:0]  r1_pmin;
    logic [KHZ_W-1:0]  r1_pmax;
    logic [KHZ_W-1:0]  r1_hwmin;
    logic [QUOT_W-1:0] r1_quot;

    // Output stage.
    logic              r_out_valid;
    logic [KHZ_W-1:0]  r_new_min;
    logic              r_boosting;
    logic              r_update;
    logic              r_taken;

    logic              in_accept;
    logic              cfg_accept;
    logic              advance;
    logic              n_update;
    logic              n_taken;
    logic              is_query;
    logic [PROD_W-1:0] div_prod;
    logic [TARGET_W-1:0] target;
    logic [TARGET_W-1:0] raised;
    logic [KHZ_W-1:0]  floor_khz;

    assign advance    = !r_out_valid || o_out.ready;
    assign i_in.ready = !r1_valid || advance;
    assign in_accept  = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign cfg_accept = i_cfg.valid && i_cfg.ready;

    // Next state of the timers and the boost flag for an accepted item.
    always_comb begin
        n_boost_active  = r_boost_active;
        n_boost_left    = r_boost_left;
        n_throttle_left = r_throttle_left;
        n_update        = 1'b0;
        n_taken         = 1'b0;
        is_query        = 1'b0;
        unique case (i_in.action)
            ACT_TICK: begin
                if (r_throttle_left != '0) begin
                    n_throttle_left = r_throttle_left - MS_W'(1);
                end
                if (r_boost_active) begin
                    if (r_boost_left <= MS_W'(1)) begin
                        n_boost_left   = '0;
                        n_boost_active = 1'b0;
                        n_update       = 1'b1;
                    end else begin
                        n_boost_left = r_boost_left - MS_W'(1);
                    end
                end
            end
            ACT_TOUCH: begin
                if (r_enable && r_throttle_left == '0) begin
                    n_taken         = 1'b1;
                    n_throttle_left = r_throttle;
                    n_boost_left    = r_duration;
                    if (!r_boost_active) begin
                        n_boost_active = 1'b1;
                        n_update       = 1'b1;
                    end
                end
            end
            ACT_QUERY: begin
                is_query = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable        <= RST_ENABLE;
            r_percent       <= RST_PERCENT;
            r_duration      <= RST_DURATION;
            r_throttle      <= RST_THROTTLE;
            r_boost_active  <= 1'b0;
            r_boost_left    <= '0;
            r_throttle_left <= '0;
        end else begin
            if (in_accept) begin
                r_boost_active  <= n_boost_active;
                r_boost_left    <= n_boost_left;
                r_throttle_left <= n_throttle_left;
            end
            if (cfg_accept) begin
                unique case (i_cfg.index)
                    CFG_ENABLE: begin
                        r_enable <= i_cfg.data[0];
                        if (!i_cfg.data[0]) begin
                            r_boost_active  <= 1'b0;
                            r_boost_left    <= '0;
                            r_throttle_left <= '0;
                        end
                    end
                    CFG_PERCENT:  r_percent  <= i_cfg.data[PCT_W-1:0];
                    CFG_DURATION: r_duration <= i_cfg.data[MS_W-1:0];
                    CFG_THROTTLE: r_throttle <= i_cfg.data[MS_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Policy maximum divided by 100.
    assign div_prod = PROD_W'(i_in.policy_max_khz) * PROD_W'(DIV100_MUL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (in_accept) begin
            r1_valid <= 1'b1;
        end else if (advance) begin
            r1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r1_boost_query <= is_query && r_boost_active;
            r1_boosting    <= n_boost_active;
            r1_update      <= n_update;
            r1_taken       <= n_taken;
            r1_pmin        <= is_query ? i_in.policy_min_khz : '0;
            r1_pmax        <= i_in.policy_max_khz;
            r1_hwmin       <= i_in.hw_min_khz;
            r1_quot        <= div_prod[DIV100_SHIFT +: QUOT_W];
        end
    end

    // Scale by the percent, raise to the hardware minimum, cap at the maximum.
    always_comb begin
        target = TARGET_W'(r1_quot) * TARGET_W'(r_percent);
        raised = (target < TARGET_W'(r1_hwmin)) ? TARGET_W'(r1_hwmin) : target;
        floor_khz = (raised > TARGET_W'(r1_pmax)) ? r1_pmax : raised[KHZ_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r1_valid) begin
            r_new_min  <= r1_boost_query ? floor_khz : r1_pmin;
            r_boosting <= r1_boosting;
            r_update   <= r1_update;
            r_taken    <= r1_taken;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.new_min_khz    = r_new_min;
    assign o_out.boosting       = r_boosting;
    assign o_out.update_request = r_update;
    assign o_out.touch_taken    = r_taken;

    // A taken touch always leaves a boost running.
    a_taken_boosts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.touch_taken) |-> o_out.boosting)
        else $error("touch taken without an active boost");

    // An update that is not from a touch is the end of a boost.
    a_update_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.update_request && !o_out.touch_taken) |-> !o_out.boosting)
        else $error("boost end reported while still boosting");

    // A disabled block holds no boost and no running timers.
    a_disabled_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_enable |-> (!r_boost_active && r_boost_left == '0 && r_throttle_left == '0))
        else $error("state left over while disabled");

    // The boost timer is zero whenever no boost runs.
    a_idle_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_boost_active |-> (r_boost_left == '0))
        else $error("boost timer running without a boost");

    // An empty output stage never blocks the input.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_in.ready)
        else $error("input stalled with empty output stage");

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking testbench for the touch boost frequency floor core.
`timescale 1ns / 1ps
module tb;
    import tbff_pkg::*;

    localparam logic [1:0]           ACT_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONE_LO = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NONE_HI = 4'hF;
    localparam logic [KHZ_W-1:0]     KHZ_MAX     = '1;
    localparam logic [CFG_DAT_W-1:0] DAT_ONES    = '1;
    localparam int PIPE_LAT    = 2;
    localparam int STALL_LIMIT = 1000;
    localparam int LONG_HOLD   = 200;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 185;

    typedef struct packed {
        logic [1:0]       act;
        logic [KHZ_W-1:0] pmax;
        logic [KHZ_W-1:0] hwmin;
        logic [KHZ_W-1:0] pmin;
    } touch_item_t;

    typedef struct packed {
        logic [KHZ_W-1:0] new_min;
        logic             boosting;
        logic             update;
        logic             taken;
    } floor_result_t;

    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_DAT_W-1:0] dat;
        touch_item_t          it;
        bit                   typed;
        floor_result_t        res;
    } script_row_t;

    logic i_clk;
    logic i_rst_n;

    tbff_in_if  in_ch ();
    tbff_out_if out_ch ();
    tbff_cfg_if cfg_ch ();

    touch_boost_frequency_floor_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    // Shadow copy of the registers and the boost state.
    logic             en_r;
    logic [PCT_W-1:0] pct_r;
    logic [MS_W-1:0]  dur_r;
    logic [MS_W-1:0]  thr_r;
    logic             boost_on;
    logic [MS_W-1:0]  boost_cnt;
    logic [MS_W-1:0]  thr_cnt;

    floor_result_t pending_q[$];
    script_row_t   plan[$];
    int            errors;
    bit            idle_on;
    bit            hold_req;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic script_row_t cfg_row(logic [CFG_IDX_W-1:0] idx,
                                            logic [CFG_DAT_W-1:0] dat);
        script_row_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.dat    = dat;
        return r;
    endfunction

    function automatic script_row_t item_row(logic [1:0] act, logic [KHZ_W-1:0] pmax,
                                             logic [KHZ_W-1:0] hwmin,
                                             logic [KHZ_W-1:0] pmin);
        script_row_t r;
        r = '{default: '0};
        r.it = '{act, pmax, hwmin, pmin};
        return r;
    endfunction

    function automatic script_row_t checked_row(logic [1:0] act, logic [KHZ_W-1:0] pmax,
                                                logic [KHZ_W-1:0] hwmin,
                                                logic [KHZ_W-1:0] pmin,
                                                logic [KHZ_W-1:0] new_min,
                                                logic boosting, logic update, logic taken);
        script_row_t r;
        r       = item_row(act, pmax, hwmin, pmin);
        r.typed = 1'b1;
        r.res   = '{new_min, boosting, update, taken};
        return r;
    endfunction

    function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] dat);
        case (idx)
            CFG_ENABLE: begin
                en_r = dat[0];
                if (!en_r) begin
                    boost_on  = 1'b0;
                    boost_cnt = '0;
                    thr_cnt   = '0;
                end
            end
            CFG_PERCENT:  pct_r = dat[PCT_W-1:0];
            CFG_DURATION: dur_r = dat[MS_W-1:0];
            CFG_THROTTLE: thr_r = dat[MS_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic floor_result_t predict_floor(touch_item_t it);
        floor_result_t r;
        logic [31:0]   target;
        r = '0;
        case (it.act)
            ACT_TICK: begin
                if (thr_cnt != 0) thr_cnt = thr_cnt - MS_W'(1);
                if (boost_on) begin
                    // A boost at one or zero ticks left ends on this tick.
                    if (boost_cnt <= 1) begin
                        boost_cnt = '0;
                        boost_on  = 1'b0;
                        r.update  = 1'b1;
                    end else begin
                        boost_cnt = boost_cnt - MS_W'(1);
                    end
                end
            end
            ACT_TOUCH: begin
                if (en_r && thr_cnt == 0) begin
                    r.taken   = 1'b1;
                    thr_cnt   = thr_r;
                    boost_cnt = dur_r;
                    if (!boost_on) begin
                        boost_on = 1'b1;
                        r.update = 1'b1;
                    end
                end
            end
            ACT_QUERY: begin
                if (boost_on) begin
                    target = (32'(it.pmax) / 32'd100) * 32'(pct_r);
                    if (target < 32'(it.hwmin)) target = 32'(it.hwmin);
                    if (target > 32'(it.pmax))  target = 32'(it.pmax);
                    r.new_min = target[KHZ_W-1:0];
                end else begin
                    r.new_min = it.pmin;
                end
            end
            default: ;
        endcase
        r.boosting = boost_on;
        return r;
    endfunction

    function automatic touch_item_t rand_item();
        touch_item_t it;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)      it.act = ACT_TICK;
        else if (pick < 65) it.act = ACT_TOUCH;
        else if (pick < 95) it.act = ACT_QUERY;
        else                it.act = ACT_UNUSED;
        case ($urandom_range(0, 3))
            0:       it.pmax = KHZ_W'($urandom);
            1:       it.pmax = KHZ_W'($urandom_range(0, 200));
            2:       it.pmax = KHZ_MAX;
            default: it.pmax = KHZ_W'($urandom & ((32'd1 << $urandom_range(1, 24)) - 1));
        endcase
        case ($urandom_range(0, 3))
            0:       it.hwmin = '0;
            1:       it.hwmin = KHZ_W'($urandom % (32'(it.pmax) + 1));
            default: it.hwmin = KHZ_W'($urandom);
        endcase
        it.pmin = KHZ_W'($urandom);
        return it;
    endfunction

    task automatic send_item(touch_item_t it, bit typed, floor_result_t res);
        int            gap;
        floor_result_t want;
        gap = idle_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.action         <= it.act;
        in_ch.policy_max_khz <= it.pmax;
        in_ch.hw_min_khz     <= it.hwmin;
        in_ch.policy_min_khz <= it.pmin;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        want = predict_floor(it);
        pending_q.push_back(typed ? res : want);
        @(negedge i_clk);
    endtask

    // Registers may only change while nothing is in flight.
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (pending_q.size() != 0) @(negedge i_clk);
        repeat (PIPE_LAT + 1) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] dat);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= dat;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        apply_cfg(idx, dat);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Result side: random stalls, plus one long hold whenever requested.
    initial begin
        int            stall;
        floor_result_t want;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = idle_on ? $urandom_range(0, 5) : 0;
            if (hold_req) begin
                stall    = LONG_HOLD;
                hold_req = 1'b0;
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (out_ch.valid !== 1'b1);
            if (pending_q.size() == 0) begin
                errors++;
                $display("%0t: result item with nothing expected, actual %h/%b/%b/%b", $time,
                         out_ch.new_min_khz, out_ch.boosting, out_ch.update_request,
                         out_ch.touch_taken);
            end else begin
                want = pending_q.pop_front();
                check_field("new_min_khz", want.new_min, out_ch.new_min_khz);
                check_field("boosting", want.boosting, out_ch.boosting);
                check_field("update_request", want.update, out_ch.update_request);
                check_field("touch_taken", want.taken, out_ch.touch_taken);
            end
            @(negedge i_clk);
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("** touch_boost_frequency_floor_core: FAILED **");
        $finish;
    end

    initial begin
        int                   pct;
        logic [CFG_DAT_W-1:0] dur;
        logic [CFG_DAT_W-1:0] thr;
        i_rst_n              = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.action         = ACT_TICK;
        in_ch.policy_max_khz = '0;
        in_ch.hw_min_khz     = '0;
        in_ch.policy_min_khz = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = CFG_ENABLE;
        cfg_ch.data          = '0;
        out_ch.ready         = 1'b0;
        errors               = 0;
        idle_on              = 1'b1;
        hold_req             = 1'b0;
        en_r      = RST_ENABLE;
        pct_r     = RST_PERCENT;
        dur_r     = RST_DURATION;
        thr_r     = RST_THROTTLE;
        boost_on  = 1'b0;
        boost_cnt = '0;
        thr_cnt   = '0;

        // Directed part, starting from the reset register values.
        plan.push_back(checked_row(ACT_QUERY, 24'd1000000, '0, 24'd12345, 24'd12345, 0, 0, 0));
        plan.push_back(checked_row(ACT_TICK, '0, '0, '0, '0, 0, 0, 0));
        plan.push_back(checked_row(ACT_UNUSED, KHZ_MAX, KHZ_MAX, KHZ_MAX, '0, 0, 0, 0));
        plan.push_back(checked_row(ACT_TOUCH, '0, '0, '0, '0, 1, 1, 1));
        plan.push_back(checked_row(ACT_TOUCH, '0, '0, '0, '0, 1, 0, 0));
        plan.push_back(item_row(ACT_QUERY, KHZ_MAX, '0, '0));
        plan.push_back(item_row(ACT_QUERY, 24'd1000, KHZ_MAX, 24'd5));
        plan.push_back(checked_row(ACT_QUERY, '0, '0, KHZ_MAX, '0, 1, 0, 0));
        plan.push_back(item_row(ACT_QUERY, 24'd99, '0, '0));
        plan.push_back(checked_row(ACT_UNUSED, KHZ_MAX, KHZ_MAX, KHZ_MAX, '0, 1, 0, 0));
        plan.push_back(cfg_row(CFG_DURATION, '0));
        plan.push_back(cfg_row(CFG_THROTTLE, '0));
        // Disabling ends the running boost.
        plan.push_back(cfg_row(CFG_ENABLE, '0));
        plan.push_back(checked_row(ACT_QUERY, KHZ_MAX, KHZ_MAX, 24'd777, 24'd777, 0, 0, 0));
        plan.push_back(checked_row(ACT_TOUCH, '0, '0, '0, '0, 0, 0, 0));
        plan.push_back(cfg_row(CFG_ENABLE, DAT_ONES));
        // Zero duration and zero throttle: every touch is taken, next tick ends the boost.
        plan.push_back(checked_row(ACT_TOUCH, '0, '0, '0, '0, 1, 1, 1));
        plan.push_back(checked_row(ACT_TOUCH, '0, '0, '0, '0, 1, 0, 1));
        plan.push_back(checked_row(ACT_TICK, '0, '0, '0, '0, 0, 1, 0));
        plan.push_back(checked_row(ACT_TICK, '0, '0, '0, '0, 0, 0, 0));
        plan.push_back(cfg_row(CFG_PERCENT, DAT_ONES));
        plan.push_back(cfg_row(CFG_NONE_HI, DAT_ONES));
        plan.push_back(cfg_row(CFG_NONE_LO, '0));
        plan.push_back(checked_row(ACT_TOUCH, '0, '0, '0, '0, 1, 1, 1));
        plan.push_back(item_row(ACT_QUERY, KHZ_MAX, '0, '0));
        plan.push_back(cfg_row(CFG_PERCENT, '0));
        plan.push_back(item_row(ACT_QUERY, 24'd5000000, 24'd123, '0));
        plan.push_back(cfg_row(CFG_DURATION, DAT_ONES));
        plan.push_back(cfg_row(CFG_THROTTLE, DAT_ONES));
        plan.push_back(checked_row(ACT_TOUCH, '0, '0, '0, '0, 1, 0, 1));
        plan.push_back(checked_row(ACT_TOUCH, '0, '0, '0, '0, 1, 0, 0));
        plan.push_back(item_row(ACT_TICK, KHZ_MAX, KHZ_MAX, KHZ_MAX));

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                settle();
                write_reg(plan[i].idx, plan[i].dat);
            end else begin
                send_item(plan[i].it, plan[i].typed, plan[i].res);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            settle();
            case (p)
                0: begin pct = 100; dur = DAT_ONES; thr = DAT_ONES; end
                1: begin pct = 0;   dur = 16'd1;    thr = '0;       end
                2: begin pct = 127; dur = '0;       thr = 16'd1;    end
                default: begin
                    pct = ($urandom_range(0, 9) == 0) ? $urandom_range(101, 127)
                                                      : $urandom_range(0, 100);
                    dur = CFG_DAT_W'($urandom_range(0, 40));
                    thr = CFG_DAT_W'($urandom_range(0, 12));
                end
            endcase
            if (p % 3 == 0) write_reg(CFG_ENABLE, '0);
            write_reg(CFG_PERCENT, 16'(pct));
            write_reg(CFG_DURATION, dur);
            write_reg(CFG_THROTTLE, thr);
            // One phase runs with the block disabled, so every touch is refused.
            write_reg(CFG_ENABLE, (p == 5) ? 16'd0 : 16'd1);
            idle_on = (p % 3 != 1);
            if (p == 4 || p == 8) hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_item(rand_item(), 1'b0, '0);
        end

        settle();
        repeat (PIPE_LAT + 8) @(negedge i_clk);
        if (errors == 0 && pending_q.size() == 0) begin
            $display("** touch_boost_frequency_floor_core: PASSED **");
        end else begin
            $display("** touch_boost_frequency_floor_core: FAILED **");
        end
        $finish;
    end

endmodule
